// ===== src/bshc_pkg.sv =====
// Shared types and constants for the byte signature hit counter.
// No dependencies; the front, the back and the core use it by scoped names.
`default_nettype none

package bshc_pkg;

	localparam int SIG_BITS     = 64;
	localparam int SIG_LEN_BITS = 4;
	localparam int COUNT_BITS   = 8;
	localparam int CFG_IDX_BITS = 2;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SIG_BYTES = 2'd0,
		CFG_SIG_LEN   = 2'd1,
		CFG_MIN_HITS  = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic                  found;
		logic [COUNT_BITS-1:0] hit_count;
	} out_item_t;

	// Classification handed from the front to the back.
	typedef struct packed {
		logic hit;
		logic last;
	} class_t;

	// Active configuration, length already clamped to the legal range.
	typedef struct packed {
		logic [SIG_BITS-1:0]     sig_bytes;
		logic [SIG_LEN_BITS-1:0] used_len;
		logic [COUNT_BITS-1:0]   min_hits;
	} cfg_t;

endpackage

`default_nettype wire

// ===== src/bshc_fifo.sv =====
// Small flip-flop queue with registered occupancy, push and pop in the same cycle.
// Depends on nothing; used between front and back and on the result side.
`default_nettype none

module bshc_fifo #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue occupancy above depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push_ok && !pop_ok) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue occupancy did not grow on push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_ok && !push_ok) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue occupancy did not shrink on pop");

endmodule

`default_nettype wire

// ===== src/bshc_front.sv =====
// Front of the hit counter: keeps the recent byte window and fill level and
// marks each byte as a signature hit or not. Depends on bshc_pkg.
`default_nettype none

module bshc_front #(
	parameter int MAX_SIG_BYTES = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire bshc_pkg::in_item_t item,
	input  wire bshc_pkg::cfg_t     cfg,
	output bshc_pkg::class_t       cls
);

	localparam int WIN_BITS  = (MAX_SIG_BYTES > 1) ? 8 * (MAX_SIG_BYTES - 1) : 8;
	localparam int FULL_BITS = WIN_BITS + 8;
	localparam int FILL_W    = $clog2(MAX_SIG_BYTES + 1);

	logic [WIN_BITS-1:0]  window_q;
	logic [FILL_W-1:0]    fill_q;
	logic [FILL_W-1:0]    fill_next;
	logic [FULL_BITS-1:0] full_w;
	logic [bshc_pkg::SIG_LEN_BITS-1:0] pos;
	logic [7:0]           have;
	logic                 match;

	assign fill_next = (fill_q < FILL_W'(MAX_SIG_BYTES)) ? fill_q + 1'b1 : fill_q;
	assign full_w    = {window_q, item.data_byte};

	// Signature byte k pairs with the window byte (len-1-k) places back.
	always_comb begin
		match = 1'b1;
		pos   = '0;
		have  = '0;
		for (int k = 0; k < MAX_SIG_BYTES; k++) begin
			pos  = cfg.used_len - 4'd1 - 4'(k);
			have = '0;
			for (int b = 0; b < MAX_SIG_BYTES; b++) begin
				if (pos == 4'(b)) begin
					have = full_w[8*b +: 8];
				end
			end
			if ((4'(k) < cfg.used_len) && (have != cfg.sig_bytes[8*k +: 8])) begin
				match = 1'b0;
			end
		end
		cls.hit  = match && (4'(fill_next) >= cfg.used_len);
		cls.last = item.last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			fill_q   <= '0;
		end else if (take) begin
			if (item.last_byte) begin
				window_q <= '0;
				fill_q   <= '0;
			end else begin
				window_q <= full_w[WIN_BITS-1:0];
				fill_q   <= fill_next;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/bshc_back.sv =====
// Back of the hit counter: applies the skip after a hit, keeps the saturating
// count and forms the result on the last byte. Depends on bshc_pkg.
`default_nettype none

module bshc_back #(
	parameter int MAX_SIG_BYTES = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire bshc_pkg::class_t  cls,
	input  wire bshc_pkg::cfg_t    cfg,
	output logic                   res_push,
	output bshc_pkg::out_item_t    res
);

	localparam int SKIP_W = (MAX_SIG_BYTES > 1) ? $clog2(MAX_SIG_BYTES) : 1;

	logic [bshc_pkg::COUNT_BITS-1:0] count_q;
	logic [bshc_pkg::COUNT_BITS-1:0] count_n;
	logic [SKIP_W-1:0]               skip_q;
	logic [SKIP_W-1:0]               skip_n;

	always_comb begin
		count_n = count_q;
		skip_n  = skip_q;
		if (skip_q != '0) begin
			skip_n = skip_q - 1'b1;
		end else if (cls.hit) begin
			if (count_q != '1) begin
				count_n = count_q + 1'b1;
			end
			skip_n = SKIP_W'(cfg.used_len - 4'd1);
		end
		res.hit_count = count_n;
		res.found     = (count_n >= cfg.min_hits);
		res_push      = take && cls.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			skip_q  <= '0;
		end else if (take) begin
			if (cls.last) begin
				count_q <= '0;
				skip_q  <= '0;
			end else begin
				count_q <= count_n;
				skip_q  <= skip_n;
			end
		end
	end

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(take && cls.last) |=> (count_q == '0 && skip_q == '0))
		else $error("scan state not cleared after last byte");

	a_skip_blocks_count: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !cls.last && skip_q != '0) |=>
		(count_q == $past(count_q) && skip_q == $past(skip_q) - 1'b1))
		else $error("count moved while skipping matched bytes");

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> ($stable(count_q) && $stable(skip_q)))
		else $error("back state moved without a transaction");

endmodule

`default_nettype wire

// ===== src/byte_signature_hit_counter_core.sv =====
// Byte signature hit counter: counts non-overlapping signature hits in a byte stream.
// Throughput one byte per cycle unless the front-to-back queue is full, set by the
// parallel window compare in the front; results leave through the result queue.
// Reset (arst_n low, asynchronous) clears queues and scan state and restores the
// registers: signature 0, length 1, minimum hits 1. Depends on bshc_pkg, bshc_fifo,
// bshc_front and bshc_back.
`default_nettype none

module byte_signature_hit_counter_core #(
	parameter int MAX_SIG_BYTES = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input queue side
	input  wire logic                                push,
	input  wire bshc_pkg::in_item_t                  data,
	output logic                                     full,
	// result queue side
	input  wire logic                                pop,
	output bshc_pkg::out_item_t                      result,
	output logic                                     empty,
	// configuration write channel
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [bshc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [bshc_pkg::SIG_BITS-1:0]       cfg_data
);

	localparam int CLS_W = $bits(bshc_pkg::class_t);
	localparam int RES_W = $bits(bshc_pkg::out_item_t);

	// Configuration registers.
	logic [bshc_pkg::SIG_BITS-1:0]     sig_q;
	logic [bshc_pkg::SIG_LEN_BITS-1:0] len_q;
	logic [bshc_pkg::COUNT_BITS-1:0]   min_hits_q;
	bshc_pkg::cfg_t                    cfg;

	// Front to back queue.
	bshc_pkg::class_t  cls_front;
	bshc_pkg::class_t  cls_back;
	logic [CLS_W-1:0]  cls_rd;
	logic              mid_full;
	logic              mid_empty;
	logic              in_take;
	logic              back_take;

	// Back to result queue.
	bshc_pkg::out_item_t res_back;
	logic                res_push;
	logic                out_full;
	logic [RES_W-1:0]    res_rd;

	// Configuration writes are always accepted: the channel never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_q      <= '0;
			len_q      <= 4'd1;
			min_hits_q <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bshc_pkg::CFG_SIG_BYTES: sig_q      <= cfg_data;
				bshc_pkg::CFG_SIG_LEN:   len_q      <= cfg_data[bshc_pkg::SIG_LEN_BITS-1:0];
				bshc_pkg::CFG_MIN_HITS:  min_hits_q <= cfg_data[bshc_pkg::COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the length: zero acts as one, anything past the window as the maximum.
	always_comb begin
		cfg.sig_bytes = sig_q;
		cfg.min_hits  = min_hits_q;
		if (len_q == '0) begin
			cfg.used_len = 4'd1;
		end else if (len_q > 4'(MAX_SIG_BYTES)) begin
			cfg.used_len = 4'(MAX_SIG_BYTES);
		end else begin
			cfg.used_len = len_q;
		end
	end

	// Accept a byte whenever the classification queue has room; the back
	// drains it whenever the result queue has room, so a waiting result
	// never stalls the byte stream until both queues fill.
	assign full      = mid_full;
	assign in_take   = push && !mid_full;
	assign back_take = !mid_empty && !out_full;
	assign cls_back  = bshc_pkg::class_t'(cls_rd);

	bshc_front #(
		.MAX_SIG_BYTES(MAX_SIG_BYTES)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (in_take),
		.item  (data),
		.cfg   (cfg),
		.cls   (cls_front)
	);

	bshc_fifo #(
		.WIDTH(CLS_W),
		.DEPTH(2)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_take),
		.wr_data(cls_front),
		.full   (mid_full),
		.pop    (back_take),
		.rd_data(cls_rd),
		.empty  (mid_empty)
	);

	bshc_back #(
		.MAX_SIG_BYTES(MAX_SIG_BYTES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (back_take),
		.cls     (cls_back),
		.cfg     (cfg),
		.res_push(res_push),
		.res     (res_back)
	);

	// Hold finished results until the consumer pops them.
	bshc_fifo #(
		.WIDTH(RES_W),
		.DEPTH(2)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wr_data(res_back),
		.full   (out_full),
		.pop    (pop),
		.rd_data(res_rd),
		.empty  (empty)
	);

	assign result = bshc_pkg::out_item_t'(res_rd);

endmodule

`default_nettype wire
